### sv/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// shared types, constants and the small mean helper of the bilinear
// bayer demosaic core
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd256;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd256;

    // floor(x/3) = (x * 683) >> 11 for x below 2048
    localparam logic [10:0] DIV3_MUL   = 11'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef logic [2:0][2:0][7:0] t_win;

    typedef struct packed {
        logic has_l;
        logic has_r;
        logic has_u;
        logic has_d;
        logic row_odd;
        logic col_odd;
    } t_edge;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic logic [7:0] mean_of(input logic [9:0] sum, input logic [2:0] cnt);
        logic [20:0] prod;
        logic [7:0]  res;
        prod = 21'(sum) * 21'(DIV3_MUL);
        case (cnt)
            3'd1: res = sum[7:0];
            3'd2: res = sum[8:1];
            3'd3: res = prod[DIV3_SHIFT+7:DIV3_SHIFT];
            3'd4: res = sum[9:2];
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

### sv/bbd_line_mem.sv
// ----------------------------------------------------------------------------
// bbd_line_mem
// line memory holding the upper and middle rows side by side, one
// synchronous read port with registered data and one write port
// ----------------------------------------------------------------------------
module bbd_line_mem #(
    parameter int DEPTH = bbd_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(bbd_pkg::MAX_WIDTH_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_data
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// bilinear color interpolation of the 3x3 window centre, border aware
// ----------------------------------------------------------------------------
module bbd_interp (
    input  bbd_pkg::t_win  i_win,
    input  bbd_pkg::t_edge i_edge,
    output bbd_pkg::t_rgb  o_rgb
);

    logic       site_red;
    logic       site_blue;
    logic [9:0] sum_plus;
    logic [2:0] cnt_plus;
    logic [9:0] sum_diag;
    logic [2:0] cnt_diag;
    logic [9:0] sum_lr;
    logic [2:0] cnt_lr;
    logic [9:0] sum_ud;
    logic [2:0] cnt_ud;
    logic [7:0] m_plus;
    logic [7:0] m_diag;
    logic [7:0] m_lr;
    logic [7:0] m_ud;
    logic       ul;
    logic       ur;
    logic       dl;
    logic       dr;

    assign site_red  = i_edge.row_odd && !i_edge.col_odd;
    assign site_blue = !i_edge.row_odd && i_edge.col_odd;

    assign ul = i_edge.has_u && i_edge.has_l;
    assign ur = i_edge.has_u && i_edge.has_r;
    assign dl = i_edge.has_d && i_edge.has_l;
    assign dr = i_edge.has_d && i_edge.has_r;

    always_comb begin
        sum_lr = (i_edge.has_l ? 10'(i_win[1][0]) : 10'd0)
               + (i_edge.has_r ? 10'(i_win[1][2]) : 10'd0);
        cnt_lr = 3'(i_edge.has_l) + 3'(i_edge.has_r);
        sum_ud = (i_edge.has_u ? 10'(i_win[0][1]) : 10'd0)
               + (i_edge.has_d ? 10'(i_win[2][1]) : 10'd0);
        cnt_ud = 3'(i_edge.has_u) + 3'(i_edge.has_d);
        sum_plus = sum_lr + sum_ud;
        cnt_plus = cnt_lr + cnt_ud;
        sum_diag = (ul ? 10'(i_win[0][0]) : 10'd0) + (ur ? 10'(i_win[0][2]) : 10'd0)
                 + (dl ? 10'(i_win[2][0]) : 10'd0) + (dr ? 10'(i_win[2][2]) : 10'd0);
        cnt_diag = 3'(ul) + 3'(ur) + 3'(dl) + 3'(dr);
    end

    assign m_plus = bbd_pkg::mean_of(sum_plus, cnt_plus);
    assign m_diag = bbd_pkg::mean_of(sum_diag, cnt_diag);
    assign m_lr   = bbd_pkg::mean_of(sum_lr, cnt_lr);
    assign m_ud   = bbd_pkg::mean_of(sum_ud, cnt_ud);

    always_comb begin
        if (site_red) begin
            o_rgb.red   = i_win[1][1];
            o_rgb.green = m_plus;
            o_rgb.blue  = m_diag;
        end else if (site_blue) begin
            o_rgb.red   = m_diag;
            o_rgb.green = m_plus;
            o_rgb.blue  = i_win[1][1];
        end else if (i_edge.row_odd) begin
            o_rgb.red   = m_lr;
            o_rgb.green = i_win[1][1];
            o_rgb.blue  = m_ud;
        end else begin
            o_rgb.red   = m_ud;
            o_rgb.green = i_win[1][1];
            o_rgb.blue  = m_lr;
        end
    end

endmodule

### sv/bayer_bilinear_demosaic_core.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core
// latency: the result register loads as the calc state that follows the input
//   transaction completes; a pixel comes out one line plus one pixel after it went in
// flow: no new transaction is taken until the read then write back of the
//   shared line memory entry is done; a held result stalls it
// reset: clears counters, window and output valid, sets the size registers
//   to their defaults; line memory contents are not cleared
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core #(
    parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_raw_pixel,
    input  logic                          i_drain,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue,
    output logic                          o_end_of_line,
    output logic                          o_end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = bbd_pkg::HEIGHT_W;
    localparam int RW = bbd_pkg::ROW_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [bbd_pkg::WIDTH_W-1:0]  r_cfg_width;
    logic [bbd_pkg::HEIGHT_W-1:0] r_cfg_height;
    logic [CW-1:0]                r_in_col;
    logic [1:0]                   r_in_row;
    logic [CW-1:0]                r_out_col;
    logic [RW-1:0]                r_out_row;
    logic [CW-1:0]                r_addr;
    logic [7:0]                   r_pix;
    logic                         r_emit;
    bbd_pkg::t_win                r_win;
    bbd_pkg::t_win                n_win;
    logic                         r_o_valid;
    bbd_pkg::t_rgb                r_rgb;
    logic                         r_eol;
    logic                         r_eof;

    logic [WW-1:0]  w;
    logic [HW-1:0]  h;
    logic           accept;
    logic           calc_go;
    logic [CW-1:0]  col_eff;
    logic [WW-1:0]  col_inc;
    logic [WW-1:0]  out_inc;
    logic [15:0]    rd_data;
    bbd_pkg::t_edge edge_i;
    bbd_pkg::t_rgb  rgb;
    logic           eol;
    logic           eof;

    // clamped sizes
    always_comb begin
        if (r_cfg_width < 11'd2) begin
            w = WW'(2);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_cfg_width);
        end
        if (r_cfg_height < 13'd2) begin
            h = HW'(2);
        end else if (32'(r_cfg_height) > bbd_pkg::MAX_HEIGHT) begin
            h = HW'(bbd_pkg::MAX_HEIGHT);
        end else begin
            h = r_cfg_height;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign calc_go = (r_state == S_CALC) && (!r_emit || !r_o_valid || i_ready);

    assign col_eff = (WW'(r_in_col) >= w) ? '0 : r_in_col;
    assign col_inc = WW'(col_eff) + WW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (calc_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    bbd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col_eff),
        .o_rd_data (rd_data),
        .i_wr_en   (calc_go),
        .i_wr_addr (r_addr),
        .i_wr_data ({rd_data[7:0], r_pix})
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = rd_data[15:8];
        n_win[1][2] = rd_data[7:0];
        n_win[2][2] = r_pix;
    end

    assign out_inc        = WW'(r_out_col) + WW'(1);
    assign edge_i.has_l   = (r_out_col != '0);
    assign edge_i.has_r   = (out_inc < w);
    assign edge_i.has_u   = (r_out_row != '0);
    assign edge_i.has_d   = ((HW'(r_out_row) + HW'(1)) < h);
    assign edge_i.row_odd = r_out_row[0];
    assign edge_i.col_odd = r_out_col[0];
    assign eol            = !edge_i.has_r;
    assign eof            = eol && !edge_i.has_d;

    bbd_interp u_interp (
        .i_win  (n_win),
        .i_edge (edge_i),
        .o_rgb  (rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= bbd_pkg::WIDTH_RESET;
            r_cfg_height <= bbd_pkg::HEIGHT_RESET;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_emit       <= 1'b0;
            r_win        <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bbd_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[bbd_pkg::WIDTH_W-1:0];
                    bbd_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_emit <= (r_in_row == 2'd2) || ((r_in_row == 2'd1) && (col_eff != '0));
                if (col_inc >= w) begin
                    r_in_col <= '0;
                    if (r_in_row != 2'd2) begin
                        r_in_row <= r_in_row + 2'd1;
                    end
                end else begin
                    r_in_col <= CW'(col_inc);
                end
            end
            if (calc_go) begin
                r_win <= n_win;
            end
            if (calc_go && r_emit) begin
                r_o_valid <= 1'b1;
                if (eof) begin
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                end else if (eol) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RW'(1);
                end else begin
                    r_out_col <= CW'(out_inc);
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // transaction payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= col_eff;
            r_pix  <= i_drain ? 8'd0 : i_raw_pixel;
        end
        if (calc_go && r_emit) begin
            r_rgb <= rgb;
            r_eol <= eol;
            r_eof <= eof;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_red          = r_rgb.red;
    assign o_green        = r_rgb.green;
    assign o_blue         = r_rgb.blue;
    assign o_end_of_line  = r_eol;
    assign o_end_of_frame = r_eof;

endmodule

### bench/bayer_bilinear_demosaic_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core_tb
// Self-checking bench for the bilinear bayer demosaic core. Raw frames of
// many sizes are streamed through the valid/ready input, including stray
// drains inside a frame, pixels inside the drain and size changes in the
// middle of a frame. A line-buffer predictor tracks every input transaction
// and queues the RGB pixel it yields; each output transaction is compared
// field by field against the oldest queued pixel. Both sides stall at random.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core_tb;

    localparam int CLK_PERIOD  = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 6;
    localparam int MEM_DEPTH   = bbd_pkg::MAX_WIDTH_DEF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_line;
        logic       end_of_frame;
    } t_demosaic_px;

    typedef struct packed {
        logic [bbd_pkg::CFG_DATA_W-1:0] w_data;
        logic [bbd_pkg::CFG_DATA_W-1:0] h_data;
        logic                           pinned;
        logic [7:0]                     level;
        logic [7:0]                     noise_pct;
    } t_frame_plan;

    // pinned rows carry a flat level, so every output pixel is that grey
    localparam t_frame_plan DIRECTED_FRAMES [3] = '{
        '{13'd2, 13'd2, 1'b1, 8'd0,   8'd0},
        '{13'd2, 13'd2, 1'b1, 8'd255, 8'd0},
        '{13'd0, 13'd1, 1'b0, 8'd0,   8'd30}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [bbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bbd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    logic [7:0]                     i_raw_pixel;
    logic                           i_drain;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [7:0]                     o_red;
    logic [7:0]                     o_green;
    logic [7:0]                     o_blue;
    logic                           o_end_of_line;
    logic                           o_end_of_frame;

    // predictor state
    logic [bbd_pkg::WIDTH_W-1:0]  width_reg;
    logic [bbd_pkg::HEIGHT_W-1:0] height_reg;
    logic [7:0]          upper_mem  [MEM_DEPTH];
    logic [7:0]          middle_mem [MEM_DEPTH];
    logic [7:0]          win [3][3];
    int unsigned         col_in;
    int unsigned         row_fill;
    int unsigned         col_out;
    int unsigned         row_out;
    int unsigned         rows_fed;
    logic                frame_done;
    logic                pin_on;
    logic [7:0]          pin_level;

    t_demosaic_px expected_px [$];
    int unsigned  n_fail;
    int unsigned  items_sent;
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    int unsigned  stall_cycles = 0;

    bayer_bilinear_demosaic_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_raw_pixel    (i_raw_pixel),
        .i_drain        (i_drain),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned used_w();
        if (width_reg < 2) return 2;
        if (width_reg > bbd_pkg::MAX_WIDTH_DEF) return bbd_pkg::MAX_WIDTH_DEF;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned used_h();
        if (height_reg < 2) return 2;
        if (height_reg > bbd_pkg::MAX_HEIGHT) return bbd_pkg::MAX_HEIGHT;
        return 32'(height_reg);
    endfunction

    function automatic int unsigned floor_mean(input int unsigned sum, input int unsigned cnt);
        return (cnt != 0) ? sum / cnt : 0;
    endfunction

    task automatic demosaic_predict(input logic [7:0] raw, input logic drn);
        int unsigned w, h, c, oc, orw, s_a, n_a, s_b, n_b, red, green, blue;
        int r;
        logic [7:0] px;
        logic emit, has_l, has_r, has_u, has_d, odd_r, odd_c, eol, eof;
        t_demosaic_px res;
        w  = used_w();
        h  = used_h();
        px = drn ? 8'd0 : raw;
        if (col_in >= w) col_in = 0;
        c = col_in;
        for (r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2]     = upper_mem[c];
        win[1][2]     = middle_mem[c];
        win[2][2]     = px;
        upper_mem[c]  = middle_mem[c];
        middle_mem[c] = px;
        emit = (row_fill >= 2) || (row_fill == 1 && col_in >= 1);
        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            if (row_fill < 2) row_fill++;
            rows_fed++;
        end
        if (!emit) return;

        oc    = col_out;
        orw   = row_out;
        has_l = oc > 0;
        has_r = oc + 1 < w;
        has_u = orw > 0;
        has_d = orw + 1 < h;
        odd_r = orw[0];
        odd_c = oc[0];
        s_a = 0; n_a = 0; s_b = 0; n_b = 0;
        if (odd_r != odd_c) begin
            // red or blue site: plus for green, diagonal for the other
            if (has_u) begin s_a += win[0][1]; n_a++; end
            if (has_d) begin s_a += win[2][1]; n_a++; end
            if (has_l) begin s_a += win[1][0]; n_a++; end
            if (has_r) begin s_a += win[1][2]; n_a++; end
            if (has_u && has_l) begin s_b += win[0][0]; n_b++; end
            if (has_u && has_r) begin s_b += win[0][2]; n_b++; end
            if (has_d && has_l) begin s_b += win[2][0]; n_b++; end
            if (has_d && has_r) begin s_b += win[2][2]; n_b++; end
            green = floor_mean(s_a, n_a);
            if (odd_r) begin
                red  = win[1][1];
                blue = floor_mean(s_b, n_b);
            end else begin
                blue = win[1][1];
                red  = floor_mean(s_b, n_b);
            end
        end else begin
            // green site: horizontal pair and vertical pair
            if (has_l) begin s_a += win[1][0]; n_a++; end
            if (has_r) begin s_a += win[1][2]; n_a++; end
            if (has_u) begin s_b += win[0][1]; n_b++; end
            if (has_d) begin s_b += win[2][1]; n_b++; end
            green = win[1][1];
            if (odd_r) begin
                red  = floor_mean(s_a, n_a);
                blue = floor_mean(s_b, n_b);
            end else begin
                blue = floor_mean(s_a, n_a);
                red  = floor_mean(s_b, n_b);
            end
        end
        if (pin_on) begin
            red   = pin_level;
            green = pin_level;
            blue  = pin_level;
        end
        eol = oc + 1 >= w;
        eof = eol && (orw + 1 >= h);
        res.red          = red[7:0];
        res.green        = green[7:0];
        res.blue         = blue[7:0];
        res.end_of_line  = eol;
        res.end_of_frame = eof;
        expected_px.push_back(res);

        if (eof) begin
            col_out    = 0;
            row_out    = 0;
            col_in     = 0;
            row_fill   = 0;
            rows_fed   = 0;
            frame_done = 1'b1;
        end else if (eol) begin
            col_out = 0;
            row_out = orw + 1;
        end else begin
            col_out = oc + 1;
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [bbd_pkg::CFG_DATA_W-1:0] w_data,
                            input logic [bbd_pkg::CFG_DATA_W-1:0] h_data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bbd_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data <= w_data;
        @(posedge i_clk);
        width_reg   = w_data[bbd_pkg::WIDTH_W-1:0];
        i_cfg_idx  <= bbd_pkg::CFG_IMAGE_HEIGHT;
        i_cfg_data <= h_data;
        @(posedge i_clk);
        height_reg  = h_data[bbd_pkg::HEIGHT_W-1:0];
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] raw, input logic drn);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_raw_pixel <= raw;
        i_drain     <= drn;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        demosaic_predict(raw, drn);
    endtask

    // limit 0 runs to the end of the frame, level below 0 means random pixels
    task automatic send_pixels(input int limit, input int unsigned noise_pct, input int level);
        int sent;
        logic drn;
        logic [7:0] raw;
        sent       = 0;
        frame_done = 1'b0;
        while (!frame_done && (limit == 0 || sent < limit)) begin
            drn = (rows_fed >= used_h());
            if ($urandom_range(99) < noise_pct) drn = !drn;
            raw = (level < 0) ? 8'($urandom_range(255)) : 8'(level);
            send_item(raw, drn);
            sent++;
        end
    endtask

    // resize part way into a frame, width never grows here
    task automatic cut_frame(input int n_cut, input logic [bbd_pkg::CFG_DATA_W-1:0] w_data,
                             input logic [bbd_pkg::CFG_DATA_W-1:0] h_data);
        send_pixels(n_cut, 0, -1);
        set_size(w_data, h_data);
        send_pixels(0, 0, -1);
    endtask

    task automatic random_run(input int n_items);
        int unsigned stop_at;
        logic [bbd_pkg::CFG_DATA_W-1:0] w_data, h_data;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0:       w_data = bbd_pkg::CFG_DATA_W'($urandom_range(1));
                1:       w_data = bbd_pkg::CFG_DATA_W'($urandom_range(16, 40));
                default: w_data = bbd_pkg::CFG_DATA_W'($urandom_range(2, 10));
            endcase
            case ($urandom_range(9))
                0:       h_data = bbd_pkg::CFG_DATA_W'($urandom_range(1));
                1:       h_data = $urandom_range(1) ? 13'd4096 : 13'h1fff;
                default: h_data = bbd_pkg::CFG_DATA_W'($urandom_range(2, 6));
            endcase
            set_size(w_data, h_data);
            repeat ($urandom_range(1, 3)) begin
                if (used_h() > 8 || $urandom_range(5) == 0) begin
                    cut_frame($urandom_range(1, 3 * used_w()),
                              bbd_pkg::CFG_DATA_W'($urandom_range(2, used_w())),
                              bbd_pkg::CFG_DATA_W'($urandom_range(0, 6)));
                end else begin
                    send_pixels(0, ($urandom_range(3) == 0) ? 4 : 0, -1);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_demosaic_px want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_px.size() == 0) begin
                $error("output transaction with no pixel expected");
                n_fail++;
            end else begin
                want = expected_px.pop_front();
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
                check_field("end_of_line", want.end_of_line, o_end_of_line);
                check_field("end_of_frame", want.end_of_frame, o_end_of_frame);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= bbd_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_raw_pixel <= 8'd0;
        i_drain     <= 1'b0;
        n_fail        = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        width_reg     = bbd_pkg::WIDTH_RESET;
        height_reg    = bbd_pkg::HEIGHT_RESET;
        foreach (upper_mem[k]) upper_mem[k] = 8'd0;
        foreach (middle_mem[k]) middle_mem[k] = 8'd0;
        foreach (win[r, c]) win[r][c] = 8'd0;
        col_in     = 0;
        row_fill   = 0;
        col_out    = 0;
        row_out    = 0;
        rows_fed   = 0;
        frame_done = 1'b0;
        pin_on     = 1'b0;
        pin_level  = 8'd0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_FRAMES[i]) begin
            set_size(DIRECTED_FRAMES[i].w_data, DIRECTED_FRAMES[i].h_data);
            pin_on    = DIRECTED_FRAMES[i].pinned;
            pin_level = DIRECTED_FRAMES[i].level;
            send_pixels(0, DIRECTED_FRAMES[i].noise_pct,
                        DIRECTED_FRAMES[i].pinned ? int'(DIRECTED_FRAMES[i].level) : -1);
            wait_idle();
            pin_on = 1'b0;
        end

        send_idle_pct = 38;
        recv_idle_pct = 77;
        random_run(40);

        send_idle_pct = 77;
        recv_idle_pct = 38;
        random_run(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // widest line, cut short and narrowed part way through the second row
        set_size(13'h1fff, 13'd2);
        cut_frame(1030, 13'd6, 13'd2);

        wait_idle();
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
